@@ hw/rtl/csx_pkg.sv @@
// Shared constants and types for the ChaCha20 stream XOR block.
package csx_pkg;

    // Default number of double rounds (20 rounds for standard ChaCha20).
    localparam int DOUBLE_ROUNDS = 10;

    // Bytes carried by one beat at most.
    localparam int LANE_BYTES = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;

    // The four "expand 32-byte k" constant words.
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // Sixteen 32-bit state words.
    typedef logic [15:0][31:0] t_words;

    // Payload of one input beat.
    typedef struct packed {
        logic [63:0] data_in;
        logic [3:0]  byte_count;
        logic        first;
        logic [31:0] start_counter;
        logic        last;
    } t_in_beat;

    // Payload of one output beat.
    typedef struct packed {
        logic [63:0] data_out;
        logic [3:0]  out_count;
        logic        out_last;
    } t_out_beat;

endpackage

@@ hw/rtl/csx_if.sv @@
// Valid/ready channel interfaces for the input and output beats.
interface csx_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_in;
    logic [3:0]  byte_count;
    logic        first;
    logic [31:0] start_counter;
    logic        last;

    modport source (output valid, output data_in, output byte_count, output first,
                    output start_counter, output last, input ready);
    modport sink (input valid, input data_in, input byte_count, input first,
                  input start_counter, input last, output ready);
endinterface

interface csx_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;
    logic [3:0]  out_count;
    logic        out_last;

    modport source (output valid, output data_out, output out_count, output out_last,
                    input ready);
    modport sink (input valid, input data_out, input out_count, input out_last,
                  output ready);
endinterface

@@ hw/rtl/chacha20_stream_xor.sv @@
// ChaCha20 keystream generator and byte-wise XOR of a message stream.
//
//  Channel  Direction  Moves
//  i_in     sink       up to eight message bytes, count, first, start counter, last
//  o_out    source     XORed bytes, count, last
//  i_cfg_*  write      key and nonce registers, one register per write
//
// A beat is accepted in idle; its bytes are XORed one at a time, an end check then
// leads to the output load, and the next beat is accepted only back in idle. A new
// keystream block loads the input words, then four shared add-xor-rotate lanes do
// one quarter-round step per cycle, and then the input words are added back one row
// per cycle. Reset is synchronous and clears the sequencer, counter, position and
// message state; a finished beat waits while the output register is full, and input
// is ready only in idle.
module chacha20_stream_xor #(
    parameter int DOUBLE_ROUNDS = csx_pkg::DOUBLE_ROUNDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [csx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                  i_cfg_data,
    csx_in_if.sink                       i_in,
    csx_out_if.source                    o_out
);

    localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Configuration registers.
    logic [63:0] r_key_a, r_key_b, r_key_c, r_key_d, r_nonce_low;
    logic [31:0] r_nonce_high;

    // Control state.
    logic [2:0]       r_state, n_state;
    logic [31:0]      r_counter, n_counter;
    logic [5:0]       r_pos, n_pos;
    logic             r_stream, n_stream;
    logic             r_fresh, n_fresh;
    logic [3:0]       r_idx, n_idx;
    logic [1:0]       r_step, n_step;
    logic             r_diag, n_diag;
    logic [RND_W-1:0] r_dround, n_dround;
    logic [1:0]       r_row, n_row;
    logic             r_ovalid, n_ovalid;

    // Payload state.
    csx_pkg::t_words r_words, n_words;
    logic [63:0]     r_data, n_data;
    logic [63:0]     r_result, n_result;
    logic [3:0]      r_cnt, n_cnt;
    logic            r_last, n_last;
    logic [63:0]     r_odata, n_odata;
    logic [3:0]      r_ocount, n_ocount;
    logic            r_olast, n_olast;

    csx_pkg::t_words init_words;
    logic            in_fire;
    logic [3:0]      clamp_cnt;
    logic [31:0]     ks_word;
    logic [7:0]      ks_byte;
    logic [7:0]      msg_byte;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a      <= '0;
            r_key_b      <= '0;
            r_key_c      <= '0;
            r_key_d      <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csx_pkg::CFG_KEY_A:      r_key_a      <= i_cfg_data;
                csx_pkg::CFG_KEY_B:      r_key_b      <= i_cfg_data;
                csx_pkg::CFG_KEY_C:      r_key_c      <= i_cfg_data;
                csx_pkg::CFG_KEY_D:      r_key_d      <= i_cfg_data;
                csx_pkg::CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                csx_pkg::CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Block input words: constants, key, counter and nonce.
    always_comb begin
        init_words[0]  = csx_pkg::SIGMA_0;
        init_words[1]  = csx_pkg::SIGMA_1;
        init_words[2]  = csx_pkg::SIGMA_2;
        init_words[3]  = csx_pkg::SIGMA_3;
        init_words[4]  = r_key_a[31:0];
        init_words[5]  = r_key_a[63:32];
        init_words[6]  = r_key_b[31:0];
        init_words[7]  = r_key_b[63:32];
        init_words[8]  = r_key_c[31:0];
        init_words[9]  = r_key_c[63:32];
        init_words[10] = r_key_d[31:0];
        init_words[11] = r_key_d[63:32];
        init_words[12] = r_counter;
        init_words[13] = r_nonce_low[31:0];
        init_words[14] = r_nonce_low[63:32];
        init_words[15] = r_nonce_high;
    end

    assign in_fire   = i_in.valid & i_in.ready;
    assign clamp_cnt = (i_in.byte_count > 4'(csx_pkg::LANE_BYTES))
                     ? 4'(csx_pkg::LANE_BYTES) : i_in.byte_count;

    // Keystream byte at the current position and the message byte it meets.
    assign ks_word  = r_words[r_pos[5:2]];
    assign ks_byte  = 8'(ks_word >> {r_pos[1:0], 3'b000});
    assign msg_byte = 8'(r_data >> {r_idx[2:0], 3'b000});

    // Sequencer and the four shared add-xor-rotate lanes.
    always_comb begin
        logic [3:0]  ia, ib, ic, id, ix, iy, iz;
        logic [31:0] sum, mix, rot;

        ia  = '0;
        ib  = '0;
        ic  = '0;
        id  = '0;
        ix  = '0;
        iy  = '0;
        iz  = '0;
        sum = '0;
        mix = '0;
        rot = '0;

        n_state  = r_state;
        n_counter = r_counter;
        n_pos    = r_pos;
        n_stream = r_stream;
        n_fresh  = r_fresh;
        n_idx    = r_idx;
        n_step   = r_step;
        n_diag   = r_diag;
        n_dround = r_dround;
        n_row    = r_row;
        n_ovalid = r_ovalid & ~o_out.ready;
        n_words  = r_words;
        n_data   = r_data;
        n_result = r_result;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_odata  = r_odata;
        n_ocount = r_ocount;
        n_olast  = r_olast;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_data   = i_in.data_in;
                    n_cnt    = clamp_cnt;
                    n_last   = i_in.last;
                    n_result = '0;
                    n_idx    = '0;
                    n_stream = ~i_in.last;
                    if (i_in.first) begin
                        n_counter = i_in.start_counter;
                        n_pos     = '0;
                        n_fresh   = 1'b0;
                    end else if (!r_stream) begin
                        n_pos   = '0;
                        n_fresh = 1'b0;
                    end
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (r_idx == r_cnt) begin
                    n_state = S_DONE;
                end else if (r_pos == '0 && !r_fresh) begin
                    // A new block is needed: load its input words and run rounds.
                    n_words  = init_words;
                    n_step   = '0;
                    n_diag   = 1'b0;
                    n_dround = '0;
                    n_state  = S_ROUND;
                end else begin
                    n_result = r_result | (64'(msg_byte ^ ks_byte) << {r_idx[2:0], 3'b000});
                    n_idx    = r_idx + 4'd1;
                    n_pos    = r_pos + 6'd1;
                    n_fresh  = 1'b0;
                    if (r_pos == 6'd63) begin
                        n_counter = r_counter + 32'd1;
                    end
                end
            end
            S_ROUND: begin
                // One quarter-round step on all four columns or diagonals.
                for (int j = 0; j < 4; j++) begin
                    ia = {2'd0, 2'(j)};
                    ib = {2'd1, 2'(j + int'(r_diag))};
                    ic = {2'd2, 2'(j + 2 * int'(r_diag))};
                    id = {2'd3, 2'(j + 3 * int'(r_diag))};
                    if (!r_step[0]) begin
                        ix = ia;
                        iy = ib;
                        iz = id;
                    end else begin
                        ix = ic;
                        iy = id;
                        iz = ib;
                    end
                    sum = r_words[ix] + r_words[iy];
                    mix = r_words[iz] ^ sum;
                    case (r_step)
                        2'd0:    rot = {mix[15:0], mix[31:16]};
                        2'd1:    rot = {mix[19:0], mix[31:20]};
                        2'd2:    rot = {mix[23:0], mix[31:24]};
                        default: rot = {mix[24:0], mix[31:25]};
                    endcase
                    n_words[ix] = sum;
                    n_words[iz] = rot;
                end
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_diag = ~r_diag;
                    if (r_diag) begin
                        if (r_dround == RND_W'(DOUBLE_ROUNDS - 1)) begin
                            n_row   = '0;
                            n_state = S_FINAL;
                        end else begin
                            n_dround = r_dround + RND_W'(1);
                        end
                    end
                end
            end
            S_FINAL: begin
                // Add the input words back, one row of four per cycle.
                for (int j = 0; j < 4; j++) begin
                    ix = {r_row, 2'(j)};
                    n_words[ix] = r_words[ix] + init_words[ix];
                end
                n_row = r_row + 2'd1;
                if (r_row == 2'd3) begin
                    n_fresh = 1'b1;
                    n_state = S_BYTE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_odata  = r_result;
                    n_ocount = r_cnt;
                    n_olast  = r_last;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_counter <= '0;
            r_pos     <= '0;
            r_stream  <= 1'b0;
            r_fresh   <= 1'b0;
            r_idx     <= '0;
            r_step    <= '0;
            r_diag    <= 1'b0;
            r_dround  <= '0;
            r_row     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_counter <= n_counter;
            r_pos     <= n_pos;
            r_stream  <= n_stream;
            r_fresh   <= n_fresh;
            r_idx     <= n_idx;
            r_step    <= n_step;
            r_diag    <= n_diag;
            r_dround  <= n_dround;
            r_row     <= n_row;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_words  <= n_words;
        r_data   <= n_data;
        r_result <= n_result;
        r_cnt    <= n_cnt;
        r_last   <= n_last;
        r_odata  <= n_odata;
        r_ocount <= n_ocount;
        r_olast  <= n_olast;
    end

    // Port drive.
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.data_out = r_odata;
    assign o_out.out_count = r_ocount;
    assign o_out.out_last = r_olast;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ChaCha20 stream XOR block.
module tb_top;

    // Indexes that no register answers to; writes there must change nothing.
    localparam logic [csx_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [csx_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int STALL_LIMIT   = 3000;
    localparam int TAIL_CYCLES   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BEATS   = 230;

    typedef enum int {SET_ALL_ONES, SET_RANDOM, SET_ZERO_NONCE} t_key_set;

    // One row of the directed table; fixed_exp rows carry a hand-typed result.
    typedef struct packed {
        csx_pkg::t_in_beat  beat;
        bit                 fixed_exp;
        csx_pkg::t_out_beat want;
    } t_stim_row;

    localparam csx_pkg::t_out_beat PREDICT = '0;
    localparam int DIR_ROWS = 24;

    // Key and nonce are all zero after reset, so the first rows follow the
    // well-known all-zero keystream block 0.
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        // No first flag after reset: keystream starts at block 0.
        '{'{64'h0, 4'd8, 1'b0, 32'h1234_5678, 1'b0}, 1'b1,
          '{64'h903d_f1a0_ade0_b876, 4'd8, 1'b0}},
        '{'{64'h0, 4'd8, 1'b0, 32'hffff_ffff, 1'b0}, 1'b1,
          '{64'h28bd_8653_e56a_5d40, 4'd8, 1'b0}},
        // A zero count uses no keystream.
        '{'{64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 32'h0, 1'b0}, 1'b1,
          '{64'h0, 4'd0, 1'b0}},
        // Counts above eight are clamped.
        '{'{64'hffff_ffff_ffff_ffff, 4'd15, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        // Short beats in the middle of a message.
        '{'{64'h0123_4567_89ab_cdef, 4'd3, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'hfedc_ba98_7654_3210, 4'd5, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'ha5a5_a5a5_a5a5_a5a5, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h5a5a_5a5a_5a5a_5a5a, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'hffff_ffff_ffff_ffff, 4'd9, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h0, 4'd8, 1'b0, 32'h0, 1'b1}, 1'b0, PREDICT},
        // Start at the top counter value and run across the wrap to block 0.
        '{'{64'h0, 4'd8, 1'b1, 32'hffff_ffff, 1'b0}, 1'b0, PREDICT},
        '{'{64'h0011_2233_4455_6677, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h8899_aabb_ccdd_eeff, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'hdead_beef_cafe_f00d, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h0000_0000_ffff_ffff, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'hffff_ffff_0000_0000, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h1357_9bdf_0246_8ace, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h8000_0000_0000_0001, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'h7fff_ffff_ffff_fffe, 4'd8, 1'b0, 32'h0, 1'b0}, 1'b0, PREDICT},
        '{'{64'hc3c3_3c3c_a5a5_5a5a, 4'd4, 1'b0, 32'h0, 1'b1}, 1'b0, PREDICT},
        // Single byte message: first keystream byte of block 0 is 0x76.
        '{'{64'hffff_ffff_ffff_ffff, 4'd1, 1'b1, 32'h0, 1'b1}, 1'b1,
          '{64'h89, 4'd1, 1'b1}},
        // First with a zero count only loads the counter.
        '{'{64'h0, 4'd0, 1'b1, 32'h5, 1'b1}, 1'b1, '{64'h0, 4'd0, 1'b1}},
        // No first while no message is open: continue from block 5, byte 0.
        '{'{64'h0, 4'd8, 1'b0, 32'hffff_ffff, 1'b0}, 1'b0, PREDICT},
        '{'{64'hffff_ffff_ffff_ffff, 4'd2, 1'b0, 32'h0, 1'b1}, 1'b0, PREDICT}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [csx_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [63:0]                   cfg_data;

    csx_in_if  in_ch ();
    csx_out_if out_ch ();

    chacha20_stream_xor dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Cipher state as the block should hold it.
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] ks_words [16];
    logic [31:0] blk_ctr;
    int unsigned byte_pos;
    bit          msg_open;

    csx_pkg::t_out_beat cipher_q [$];
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          hold_req;
    int unsigned err_count;
    int unsigned beats_sent;
    int unsigned msgs_sent;
    int unsigned blocks_made;
    int unsigned ctr_wraps;
    int unsigned cfg_writes;
    int unsigned idle_cycles;

    function automatic logic [127:0] quarter_round(input logic [31:0] a, input logic [31:0] b,
                                                   input logic [31:0] c, input logic [31:0] d);
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

    // Build the 64-byte keystream block for the current counter, key and nonce.
    function automatic void refill_keystream();
        logic [31:0] init_w [16];
        logic [31:0] w [16];
        int r;
        init_w[0]  = csx_pkg::SIGMA_0;
        init_w[1]  = csx_pkg::SIGMA_1;
        init_w[2]  = csx_pkg::SIGMA_2;
        init_w[3]  = csx_pkg::SIGMA_3;
        for (r = 0; r < 4; r++) begin
            init_w[4 + 2 * r] = key_reg[r][31:0];
            init_w[5 + 2 * r] = key_reg[r][63:32];
        end
        init_w[12] = blk_ctr;
        init_w[13] = nonce_lo_reg[31:0];
        init_w[14] = nonce_lo_reg[63:32];
        init_w[15] = nonce_hi_reg;
        w = init_w;
        for (r = 0; r < csx_pkg::DOUBLE_ROUNDS; r++) begin
            {w[0], w[4], w[8],  w[12]} = quarter_round(w[0], w[4], w[8],  w[12]);
            {w[1], w[5], w[9],  w[13]} = quarter_round(w[1], w[5], w[9],  w[13]);
            {w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
            {w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
            {w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
            {w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
            {w[2], w[7], w[8],  w[13]} = quarter_round(w[2], w[7], w[8],  w[13]);
            {w[3], w[4], w[9],  w[14]} = quarter_round(w[3], w[4], w[9],  w[14]);
        end
        for (r = 0; r < 16; r++)
            ks_words[r] = w[r] + init_w[r];
        blocks_made++;
    endfunction

    // XOR one beat with the keystream and advance the stream position.
    function automatic csx_pkg::t_out_beat cipher_beat(input csx_pkg::t_in_beat b);
        csx_pkg::t_out_beat res;
        int unsigned n;
        int unsigned i;
        n = (b.byte_count > csx_pkg::LANE_BYTES) ? csx_pkg::LANE_BYTES : b.byte_count;
        if (b.first) begin
            blk_ctr  = b.start_counter;
            byte_pos = 0;
        end else if (!msg_open) begin
            byte_pos = 0;
        end
        res = '0;
        for (i = 0; i < n; i++) begin
            if (byte_pos == 0)
                refill_keystream();
            res.data_out[8 * i +: 8] = b.data_in[8 * i +: 8]
                                     ^ ks_words[byte_pos / 4][8 * (byte_pos % 4) +: 8];
            byte_pos++;
            if (byte_pos == 64) begin
                byte_pos = 0;
                blk_ctr  = blk_ctr + 32'd1;
                if (blk_ctr == 32'd0)
                    ctr_wraps++;
            end
        end
        msg_open      = !b.last;
        res.out_count = 4'(n);
        res.out_last  = b.last;
        return res;
    endfunction

    function automatic void store_reg(input logic [csx_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [63:0] val);
        case (idx)
            csx_pkg::CFG_KEY_A:      key_reg[0]   = val;
            csx_pkg::CFG_KEY_B:      key_reg[1]   = val;
            csx_pkg::CFG_KEY_C:      key_reg[2]   = val;
            csx_pkg::CFG_KEY_D:      key_reg[3]   = val;
            csx_pkg::CFG_NONCE_LOW:  nonce_lo_reg = val;
            csx_pkg::CFG_NONCE_HIGH: nonce_hi_reg = val[31:0];
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] key_value(input t_key_set kind);
        return (kind == SET_ALL_ONES) ? '1 : {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Offer one beat; entered and left at a falling edge, valid left high.
    task automatic send_beat(input csx_pkg::t_in_beat b, input bit fixed_exp,
                             input csx_pkg::t_out_beat want);
        csx_pkg::t_out_beat pred;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_in       <= b.data_in;
        in_ch.byte_count    <= b.byte_count;
        in_ch.first         <= b.first;
        in_ch.start_counter <= b.start_counter;
        in_ch.last          <= b.last;
        do @(posedge clk); while (!in_ch.ready);
        pred = cipher_beat(b);
        cipher_q.push_back(fixed_exp ? want : pred);
        beats_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected beat has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (cipher_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [csx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        store_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic load_settings(input t_key_set kind);
        cfg_write(csx_pkg::CFG_KEY_A, key_value(kind));
        cfg_write(csx_pkg::CFG_KEY_B, key_value(kind));
        cfg_write(csx_pkg::CFG_KEY_C, key_value(kind));
        cfg_write(csx_pkg::CFG_KEY_D, key_value(kind));
        cfg_write(csx_pkg::CFG_NONCE_LOW,
                  (kind == SET_ZERO_NONCE) ? 64'h0 : key_value(kind));
        cfg_write(csx_pkg::CFG_NONCE_HIGH,
                  (kind == SET_ZERO_NONCE) ? 64'h0 : key_value(kind));
        cfg_write(CFG_SPARE_A, {$urandom, $urandom});
        cfg_write(CFG_SPARE_B, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    // Change key and nonce in the middle of an open message, then run the
    // message on past the next block boundary so both keys are used.
    task automatic switch_keys_mid_message(input t_key_set kind);
        csx_pkg::t_in_beat b;
        int k;
        b.data_in       = {$urandom, $urandom};
        b.byte_count    = 4'($urandom_range(1, 7));
        b.first         = 1'b1;
        b.start_counter = $urandom;
        b.last          = 1'b0;
        send_beat(b, 1'b0, PREDICT);
        wait_drained();
        load_settings(kind);
        for (k = 0; k < 9; k++) begin
            b.data_in    = {$urandom, $urandom};
            b.byte_count = 4'd8;
            b.first      = 1'b0;
            b.last       = (k == 8);
            send_beat(b, 1'b0, PREDICT);
        end
    endtask

    // Mostly well-formed messages, with stray flags and odd counts mixed in.
    task automatic send_message();
        csx_pkg::t_in_beat b;
        int unsigned n_beats;
        int unsigned k;
        bit          drop_first;
        bit          drop_last;
        n_beats    = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
        drop_first = ($urandom_range(15) == 0);
        drop_last  = ($urandom_range(19) == 0);
        for (k = 0; k < n_beats; k++) begin
            b.data_in       = {$urandom, $urandom};
            b.start_counter = ($urandom_range(7) == 0) ? 32'hffff_ffff - $urandom_range(2)
                                                      : $urandom;
            b.first = (k == 0) ? !drop_first : ($urandom_range(31) == 0);
            if (k == n_beats - 1) begin
                b.last       = !drop_last;
                b.byte_count = 4'($urandom_range(1, 8));
            end else begin
                b.last       = ($urandom_range(31) == 0);
                b.byte_count = ($urandom_range(11) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            end
            send_beat(b, 1'b0, PREDICT);
        end
        msgs_sent++;
    endtask

    // Output side: random back-pressure plus one long hold-off on request.
    initial begin : sink_ctl
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Compare each output beat with the oldest expected one.
    always @(posedge clk) begin : out_check
        csx_pkg::t_out_beat want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (cipher_q.size() == 0) begin
                report_mismatch("unexpected beat", out_ch.data_out, 64'h0);
            end else begin
                want = cipher_q.pop_front();
                if (out_ch.data_out !== want.data_out)
                    report_mismatch("data_out", out_ch.data_out, want.data_out);
                if (out_ch.out_count !== want.out_count)
                    report_mismatch("out_count", 64'(out_ch.out_count), 64'(want.out_count));
                if (out_ch.out_last !== want.out_last)
                    report_mismatch("out_last", 64'(out_ch.out_last), 64'(want.out_last));
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d beats outstanding",
                     idle_cycles, cipher_q.size());
            $display("chacha20_stream_xor verification failed");
            $finish;
        end
    end

    initial begin : main_seq
        t_key_set    kinds [3];
        int unsigned phase_start;
        int          ph;
        int          r;
        bit          hold_asked;
        bit          paused;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = csx_pkg::CFG_KEY_A;
        cfg_data            = 64'h0;
        in_ch.valid         = 1'b0;
        in_ch.data_in       = 64'h0;
        in_ch.byte_count    = 4'd0;
        in_ch.first         = 1'b0;
        in_ch.start_counter = 32'h0;
        in_ch.last          = 1'b0;
        out_ch.ready        = 1'b0;
        hold_req            = 1'b0;
        err_count           = 0;
        beats_sent          = 0;
        msgs_sent           = 0;
        blocks_made         = 0;
        ctr_wraps           = 0;
        cfg_writes          = 0;
        idle_cycles         = 0;
        src_idle_pct        = 36;
        snk_idle_pct        = 50;
        for (r = 0; r < 4; r++)
            key_reg[r] = 64'h0;
        nonce_lo_reg = 64'h0;
        nonce_hi_reg = 32'h0;
        blk_ctr      = 32'h0;
        byte_pos     = 0;
        msg_open     = 1'b0;
        kinds        = '{SET_ALL_ONES, SET_RANDOM, SET_ZERO_NONCE};
        hold_asked   = 1'b0;
        paused       = 1'b0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table with the reset key and nonce.
        for (r = 0; r < DIR_ROWS; r++)
            send_beat(DIRECTED[r].beat, DIRECTED[r].fixed_exp, DIRECTED[r].want);

        // Random phases, each with its own key set and idle profile.
        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 50 : 0;
            snk_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 36 : 0;
            switch_keys_mid_message(kinds[ph]);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if (ph == 0 && !hold_asked && beats_sent - phase_start >= 100) begin
                    hold_req   = 1'b1;
                    hold_asked = 1'b1;
                end
                if (ph == 1 && !paused && beats_sent - phase_start >= 125) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_message();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d beats (%0d directed, %0d random messages), %0d keystream blocks,",
                 beats_sent, DIR_ROWS, msgs_sent, blocks_made);
        $display("  %0d counter wraps, %0d register writes, %0d mismatches.",
                 ctr_wraps, cfg_writes, err_count);
        if (err_count == 0) begin
            $display("chacha20_stream_xor verification clean");
        end else begin
            $display("chacha20_stream_xor verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/csx_pkg.sv
hw/rtl/csx_if.sv
hw/rtl/chacha20_stream_xor.sv
verif/tb_top.sv
